FILE: rtl/msp_v1_frame_receiver_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef MSP_V1_FRAME_RECEIVER_MACROS_SVH
`define MSP_V1_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define MSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/msp_pkg.sv
`default_nettype none

package msp_pkg;

	// Largest payload a frame may announce; a bigger size byte restarts the hunt.
	localparam int MAX_PAYLOAD = 32;
	localparam int SIZE_W      = $clog2(MAX_PAYLOAD + 1);

	localparam int BYTE_W    = 8;
	localparam int OFS_W     = 21;
	localparam int ALT_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int HEAD_N    = 4;

	// Frame start and direction characters.
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
	localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;

	localparam logic [BYTE_W-1:0] ALT_CMD_RESET = 8'd109;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALT_CMD    = 1'b0,
		REG_HEIGHT_OFS = 1'b1
	} cfg_reg_t;

	// What the parser reports for one byte.
	typedef struct packed {
		logic              frame_end;
		logic              frame_good;
		logic [BYTE_W-1:0] frame_code;
		logic              latch;
		logic [ALT_W-1:0]  alt_word;
	} msp_evt_t;

endpackage

`default_nettype wire

FILE: rtl/msp_parser.sv
`default_nettype none

module msp_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [msp_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic [msp_pkg::BYTE_W-1:0] alt_cmd,
	output msp_pkg::msp_evt_t               evt
);
	import msp_pkg::*;

	typedef enum logic [2:0] {
		PH_DOLLAR = 3'd0,
		PH_M      = 3'd1,
		PH_DIR    = 3'd2,
		PH_SIZE   = 3'd3,
		PH_CODE   = 3'd4,
		PH_DATA   = 3'd5,
		PH_SUM    = 3'd6
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [SIZE_W-1:0]   size_q, size_d;
	logic [SIZE_W-1:0]   count_q, count_d;
	logic [BYTE_W-1:0]   code_q, code_d;
	logic [BYTE_W-1:0]   xor_q, xor_d;
	logic [BYTE_W-1:0]   head_q [HEAD_N];
	logic                head_we;

	// Next state and per-byte report from the current phase and the byte.
	always_comb begin
		phase_d = phase_q;
		size_d  = size_q;
		count_d = count_q;
		code_d  = code_q;
		xor_d   = xor_q;
		head_we = 1'b0;
		evt     = '0;
		evt.alt_word = {head_q[3], head_q[2], head_q[1], head_q[0]};
		unique case (phase_q)
			PH_DOLLAR: begin
				if (rx_byte == CH_DOLLAR) phase_d = PH_M;
			end
			PH_M: begin
				phase_d = (rx_byte == CH_M) ? PH_DIR : PH_DOLLAR;
			end
			PH_DIR: begin
				phase_d = (rx_byte == CH_GT || rx_byte == CH_BANG) ? PH_SIZE : PH_DOLLAR;
			end
			PH_SIZE: begin
				if (rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
					phase_d = PH_DOLLAR;
					size_d  = '0;
					count_d = '0;
					xor_d   = '0;
				end else begin
					size_d  = rx_byte[SIZE_W-1:0];
					count_d = '0;
					xor_d   = rx_byte;
					phase_d = PH_CODE;
				end
			end
			PH_CODE: begin
				code_d  = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				phase_d = (size_q == '0) ? PH_SUM : PH_DATA;
			end
			PH_DATA: begin
				head_we = (count_q < SIZE_W'(HEAD_N));
				xor_d   = xor_q ^ rx_byte;
				count_d = count_q + 1'b1;
				if (count_d >= size_q) phase_d = PH_SUM;
			end
			PH_SUM: begin
				evt.frame_end  = 1'b1;
				evt.frame_code = code_q;
				if (xor_q == rx_byte) begin
					evt.frame_good = 1'b1;
					evt.latch = (code_q == alt_cmd) && (size_q >= SIZE_W'(HEAD_N));
				end
				phase_d = PH_DOLLAR;
				size_d  = '0;
				count_d = '0;
				xor_d   = '0;
			end
			default: begin
				phase_d = PH_DOLLAR;
				size_d  = '0;
				count_d = '0;
				xor_d   = '0;
			end
		endcase
	end

	// Parser state advances once per byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DOLLAR;
			size_q  <= '0;
			count_q <= '0;
			code_q  <= '0;
			xor_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			count_q <= count_d;
			code_q  <= code_d;
			xor_q   <= xor_d;
		end
	end

	// The first payload bytes of the frame; written before any read.
	always_ff @(posedge clk) begin
		if (step && head_we) begin
			head_q[count_q[1:0]] <= rx_byte;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/msp_v1_frame_receiver.sv
// Channel  Handshake               Payload
// -------  ----------------------  -----------------------------------------------
// in       in_valid / in_ready     rx_byte
// out      out_valid / out_ready   frame_end, frame_good, frame_code,
//                                  altitude_updated, altitude_known, altitude_cm
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data (cfg_ready is always high)
//
// One byte per cycle is sustained while out_ready keeps the output moving.
// The byte is registered, parsed combinationally, and its result held in an output register.
// A stalled output holds the byte stage; in_ready drops only when both stages are full.
// Reset restarts the hunt for '$', forgets the altitude and restores the register defaults.
`default_nettype none

module msp_v1_frame_receiver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [msp_pkg::BYTE_W-1:0]    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               frame_end,
	output logic                               frame_good,
	output logic [msp_pkg::BYTE_W-1:0]         frame_code,
	output logic                               altitude_updated,
	output logic                               altitude_known,
	output logic signed [msp_pkg::ALT_W-1:0]   altitude_cm,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [msp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [msp_pkg::OFS_W-1:0]     cfg_data
);
	import msp_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                out_valid_q;
	logic                frame_end_q;
	logic                frame_good_q;
	logic [BYTE_W-1:0]   frame_code_q;
	logic                updated_q;
	logic                known_q;
	logic [ALT_W-1:0]    alt_q;
	logic [ALT_W-1:0]    alt_cm_q;
	logic [BYTE_W-1:0]   alt_cmd_q;
	logic [OFS_W-1:0]    ofs_q;
	logic                advance;
	logic                step;
	logic [ALT_W-1:0]    alt_next;
	msp_evt_t            evt;

	// Handshake: the output register frees the byte stage, which frees the input.
	assign advance   = !out_valid_q || out_ready;
	assign step      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	msp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.alt_cmd (alt_cmd_q),
		.evt     (evt)
	);

	// Altitude after this byte; the sign-extended height offset is subtracted when the result is registered.
	assign alt_next = evt.latch ? evt.alt_word : alt_q;

	// Control state and the stored altitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			alt_q       <= '0;
			known_q     <= 1'b0;
			alt_cmd_q   <= ALT_CMD_RESET;
			ofs_q       <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) out_valid_q <= valid_s1;
			if (step && evt.latch) begin
				alt_q   <= evt.alt_word;
				known_q <= 1'b1;
			end
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_ALT_CMD:    alt_cmd_q <= cfg_data[BYTE_W-1:0];
					REG_HEIGHT_OFS: ofs_q     <= cfg_data;
				endcase
			end
		end
	end

	// Byte stage and result payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
		if (step) begin
			frame_end_q  <= evt.frame_end;
			frame_good_q <= evt.frame_good;
			frame_code_q <= evt.frame_code;
			updated_q    <= evt.latch;
			alt_cm_q     <= alt_next - {{(ALT_W-OFS_W){ofs_q[OFS_W-1]}}, ofs_q};
		end
	end

	assign out_valid        = out_valid_q;
	assign frame_end        = frame_end_q;
	assign frame_good       = frame_good_q;
	assign frame_code       = frame_code_q;
	assign altitude_updated = updated_q;
	assign altitude_known   = known_q;
	assign altitude_cm      = signed'(alt_cm_q);

endmodule

`default_nettype wire

FILE: rtl/msp_checker.sv
`default_nettype none
`include "msp_v1_frame_receiver_macros.svh"

module msp_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          frame_end,
	input wire logic                          frame_good,
	input wire logic [msp_pkg::BYTE_W-1:0]    frame_code,
	input wire logic                          altitude_updated,
	input wire logic                          altitude_known,
	input wire logic signed [msp_pkg::ALT_W-1:0] altitude_cm
);
	import msp_pkg::*;

	// A stalled result word keeps out_valid, frame_end, frame_good, frame_code and altitude_cm.
	`MSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_end) && $stable(frame_good) && $stable(frame_code) && $stable(altitude_cm), "result word changed while stalled")

	// A good checksum only ever comes with a frame end.
	`MSP_ASSERT_NOW(a_good_end, out_valid && frame_good, frame_end, "frame_good without frame_end")

	// A new altitude needs a good frame and marks the altitude as known.
	`MSP_ASSERT_NOW(a_update_good, out_valid && altitude_updated, frame_good && altitude_known, "altitude update without good frame")

	// Outside a frame end the command code reads as zero and no altitude update is flagged.
	`MSP_ASSERT_NOW(a_code_idle, out_valid && !frame_end, frame_code == '0 && !altitude_updated, "frame status set on a non-checksum word")

endmodule

bind msp_v1_frame_receiver msp_checker u_msp_checker (.*);

`default_nettype wire
